// ----- sv/bcd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the block cache directory.
// No dependencies; the interfaces and the directory module import this package.
package bcd_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int CMD_W    = 2;
  localparam int HANDLE_W = 8;
  localparam int BLOCK_W  = 64;
  localparam int STAMP_W  = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_O_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_INVAL = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT   = 3'd0,
    ST_MISS  = 3'd1,
    ST_ERR   = 3'd2,
    ST_FLUSH = 3'd3,
    ST_DONE  = 3'd4
  } status_t;

  // One directory entry as stored in the slot memory.
  typedef struct packed {
    logic [BLOCK_W-1:0]  block;
    logic [HANDLE_W-1:0] owner;
    logic                dirty;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

endpackage

// ----- sv/bcd_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels of the block cache directory: request and result.
// Depends on bcd_pkg for field widths.
interface bcd_in_if import bcd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [HANDLE_W-1:0] req_handle;
  logic [BLOCK_W-1:0]  block_number;
  logic                all_handles;
  logic                backing_ok;

  modport source (output valid, command, req_handle, block_number, all_handles,
                  backing_ok, input ready);
  modport sink (input valid, command, req_handle, block_number, all_handles,
                backing_ok, output ready);
endinterface

interface bcd_out_if import bcd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_O_W-1:0] slot;
  logic                evict_writeback;
  logic [BLOCK_W-1:0]  victim_block;
  logic [HANDLE_W-1:0] victim_handle;
  logic                last;

  modport source (output valid, status, slot, evict_writeback, victim_block,
                  victim_handle, last, input ready);
  modport sink (input valid, status, slot, evict_writeback, victim_block,
                victim_handle, last, output ready);
endinterface

// ----- sv/block_cache_directory.sv -----
`timescale 1ns / 1ps
// Fully associative write-back cache directory, LRU by use stamp.
// Depends on bcd_pkg, bcd_in_if/bcd_out_if and bcd_ram.

// Every command walks the slot memory once, one read a cycle while no flush
// writeback beat waits on the result port, and ends in a decide/write-back
// step that waits until the output register is free. The walk is bound by
// the one read port of the slot memory. Entries that were never written read
// as empty through per-slot valid bits cleared by reset, so no clearing pass
// follows reset. Results leave through an output register, so a finished
// result may wait while the next request is taken.
module block_cache_directory import bcd_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bcd_in_if.sink    in_ch,
  bcd_out_if.source out_ch
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int ENT_W  = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // latched request
  cmd_t                cmd_r;
  logic [HANDLE_W-1:0] hdl_r;
  logic [BLOCK_W-1:0]  blk_r;
  logic                all_r;
  logic                ok_r;

  logic [CNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [SLOT_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic [SLOTS-1:0]    vld_r;
  logic                vld_q_r;
  logic [STAMP_W-1:0]  use_clk_r, use_clk_nxt;

  // lookup / victim search results
  logic                hit_f_r, hit_f_nxt;
  logic [SLOT_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic                hit_dirty_r, hit_dirty_nxt;
  logic                emp_f_r, emp_f_nxt;
  logic [SLOT_W-1:0]   emp_idx_r, emp_idx_nxt;
  logic [STAMP_W-1:0]  best_stamp_r, best_stamp_nxt;
  logic [SLOT_W-1:0]   best_idx_r, best_idx_nxt;
  logic [BLOCK_W-1:0]  best_block_r, best_block_nxt;
  logic [HANDLE_W-1:0] best_owner_r, best_owner_nxt;
  logic                best_dirty_r, best_dirty_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_O_W-1:0] out_slot_r, out_slot_nxt;
  logic                out_ev_r, out_ev_nxt;
  logic [BLOCK_W-1:0]  out_vb_r, out_vb_nxt;
  logic [HANDLE_W-1:0] out_vh_r, out_vh_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_free, out_load;

  // memory port
  logic                ram_we, ram_re;
  logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
  entry_t              ram_wdata, ram_q, ent;
  logic [ENT_W-1:0]    ram_rdata;

  logic                accept, advance, fl_match, proc, scan_end;
  logic                rw_cmd, is_miss, wb;
  logic [SLOT_W-1:0]   res_idx, vic_idx;
  logic [SLOT_W+3:0]   slot_ext;
  logic [STAMP_W-1:0]  stamp_new;

  bcd_ram #(
    .WIDTH(ENT_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ram_q = entry_t'(ram_rdata);
  assign ent   = vld_q_r ? ram_q : entry_t'('0);

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign fl_match  = (ent.block != '0) && (all_r || ent.owner == hdl_r) && ent.dirty;
  // a flush writeback beat holds the walk until the output register frees
  assign advance   = !(chk_vld_r && cmd_r == CMD_FLUSH && fl_match && !out_free);
  assign proc      = (state_r == S_SCAN) && chk_vld_r && advance;
  assign scan_end  = (rd_cnt_r == CNT_W'(SLOTS));
  assign ram_re    = (state_r == S_SCAN) && advance && !scan_end;
  assign ram_raddr = rd_cnt_r[SLOT_W-1:0];

  assign rw_cmd    = (cmd_r == CMD_READ) || (cmd_r == CMD_WRITE);
  assign is_miss   = !hit_f_r;
  assign wb        = !emp_f_r && best_dirty_r && (best_block_r != '0);
  assign vic_idx   = emp_f_r ? emp_idx_r : best_idx_r;
  assign stamp_new = use_clk_r + STAMP_W'(1);

  always_comb begin
    state_nxt      = state_r;
    rd_cnt_nxt     = rd_cnt_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    use_clk_nxt    = use_clk_r;
    hit_f_nxt      = hit_f_r;
    hit_idx_nxt    = hit_idx_r;
    hit_dirty_nxt  = hit_dirty_r;
    emp_f_nxt      = emp_f_r;
    emp_idx_nxt    = emp_idx_r;
    best_stamp_nxt = best_stamp_r;
    best_idx_nxt   = best_idx_r;
    best_block_nxt = best_block_r;
    best_owner_nxt = best_owner_r;
    best_dirty_nxt = best_dirty_r;
    ram_we         = 1'b0;
    ram_waddr      = chk_idx_r;
    ram_wdata      = ent;
    out_load       = 1'b0;
    out_status_nxt = ST_DONE;
    res_idx        = '0;
    out_ev_nxt     = 1'b0;
    out_vb_nxt     = '0;
    out_vh_nxt     = '0;
    out_last_nxt   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt   = S_SCAN;
          rd_cnt_nxt  = '0;
          chk_vld_nxt = 1'b0;
          hit_f_nxt   = 1'b0;
          emp_f_nxt   = 1'b0;
        end
      end

      S_SCAN: begin
        if (advance) begin
          chk_vld_nxt = !scan_end;
          chk_idx_nxt = ram_raddr;
          if (!scan_end) begin
            rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
          end else begin
            state_nxt = S_FIN;
          end
        end
        if (proc) begin
          case (cmd_r) inside
            CMD_READ, CMD_WRITE: begin
              if (!hit_f_r && blk_r != '0 && ent.block == blk_r && ent.owner == hdl_r) begin
                hit_f_nxt     = 1'b1;
                hit_idx_nxt   = chk_idx_r;
                hit_dirty_nxt = ent.dirty;
              end
              // slot 0 is never taken as an empty slot, only by stamp
              if (!emp_f_r && chk_idx_r != '0 && ent.block == '0) begin
                emp_f_nxt   = 1'b1;
                emp_idx_nxt = chk_idx_r;
              end
              if (chk_idx_r == '0 || ent.stamp < best_stamp_r) begin
                best_stamp_nxt = ent.stamp;
                best_idx_nxt   = chk_idx_r;
                best_block_nxt = ent.block;
                best_owner_nxt = ent.owner;
                best_dirty_nxt = ent.dirty;
              end
            end
            CMD_FLUSH: begin
              if (fl_match) begin
                ram_we          = 1'b1;
                ram_wdata.dirty = 1'b0;
                out_load        = 1'b1;
                out_status_nxt  = ST_FLUSH;
                res_idx         = chk_idx_r;
                out_vb_nxt      = ent.block;
                out_vh_nxt      = ent.owner;
                out_last_nxt    = 1'b0;
              end
            end
            default: begin
              if (ent.owner == hdl_r) begin
                ram_we          = 1'b1;
                ram_wdata.block = '0;
                ram_wdata.dirty = 1'b0;
              end
            end
          endcase
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (rw_cmd) begin
            ram_wdata.block = blk_r;
            ram_wdata.owner = hdl_r;
            ram_wdata.stamp = stamp_new;
            if (!is_miss) begin
              ram_we          = 1'b1;
              ram_waddr       = hit_idx_r;
              ram_wdata.dirty = hit_dirty_r || (cmd_r == CMD_WRITE);
              use_clk_nxt     = stamp_new;
              out_status_nxt  = ST_HIT;
              res_idx         = hit_idx_r;
            end else if (cmd_r == CMD_READ && !ok_r) begin
              out_status_nxt = ST_ERR;
            end else begin
              ram_we          = 1'b1;
              ram_waddr       = vic_idx;
              ram_wdata.dirty = (cmd_r == CMD_WRITE);
              use_clk_nxt     = stamp_new;
              out_status_nxt  = ST_MISS;
              res_idx         = vic_idx;
              out_ev_nxt      = wb;
              out_vb_nxt      = wb ? best_block_r : '0;
              out_vh_nxt      = wb ? best_owner_r : '0;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // slot field is reported modulo 16
    slot_ext     = {4'b0000, res_idx};
    out_slot_nxt = slot_ext[3:0];

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_cnt_r    <= '0;
      chk_vld_r   <= 1'b0;
      vld_r       <= '0;
      vld_q_r     <= 1'b0;
      use_clk_r   <= '0;
      out_valid_r <= 1'b0;
      hit_f_r     <= 1'b0;
      emp_f_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      use_clk_r   <= use_clk_nxt;
      out_valid_r <= out_valid_nxt;
      hit_f_r     <= hit_f_nxt;
      emp_f_r     <= emp_f_nxt;
      if (ram_re) begin
        vld_q_r <= vld_r[ram_raddr];
      end
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_ch.command);
      hdl_r <= in_ch.req_handle;
      blk_r <= in_ch.block_number;
      all_r <= in_ch.all_handles;
      ok_r  <= in_ch.backing_ok;
    end
    chk_idx_r    <= chk_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_dirty_r  <= hit_dirty_nxt;
    emp_idx_r    <= emp_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_idx_r   <= best_idx_nxt;
    best_block_r <= best_block_nxt;
    best_owner_r <= best_owner_nxt;
    best_dirty_r <= best_dirty_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_ev_r     <= out_ev_nxt;
      out_vb_r     <= out_vb_nxt;
      out_vh_r     <= out_vh_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.slot            = out_slot_r;
  assign out_ch.evict_writeback = out_ev_r;
  assign out_ch.victim_block    = out_vb_r;
  assign out_ch.victim_handle   = out_vh_r;
  assign out_ch.last            = out_last_r;

  // the walk never writes the entry it is reading in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("slot memory read and write collide");

  // the use clock moves only in the decide cycle
  a_clock_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
    use_clk_r != $past(use_clk_r) |-> $past(state_r) == S_FIN)
    else $error("use clock changed outside decide cycle");

  // a pending entry check exists only during the walk
  a_chk_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> state_r == S_SCAN)
    else $error("entry check outside walk");

  // a writeback beat never carries the last mark
  a_flush_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && out_status_nxt == ST_FLUSH |=> out_valid_r && !out_last_r)
    else $error("flush writeback marked last");

endmodule

// ----- sv/bcd_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
